// ----- src/dggp_pkg.sv -----
// Package for the decal glyph grid projection: widths, codes, sine coefficients, item side data.
`default_nettype none
package dggp_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int TRIG_BITS_DEF  = 10;

  localparam int EXT_W    = 32;
  localparam int COMP_W   = 16;
  localparam int COMP_FR  = 8;
  localparam int CNT_W    = 8;
  localparam int NUM_W    = EXT_W + COMP_FR;
  localparam int DEN_W    = CNT_W + COMP_W;
  localparam int OFS_W    = CNT_W + 2;
  localparam int COORD_W  = 32;

  localparam logic [31:0] SINE_K [6] = '{
    32'd3864, 32'd172272, 32'd5026996, 32'd85569306, 32'd693598667, 32'd1686629713
  };

  typedef enum logic [2:0] {
    REG_ANGLE    = 3'd0,
    REG_SURFACE  = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_ORIGIN_Z = 3'd4,
    REG_EXTENT   = 3'd5,
    REG_GRID     = 3'd6,
    REG_STEP     = 3'd7
  } reg_idx_t;

  localparam logic [1:0] SURF_WALL = 2'd0;

  typedef struct packed {
    logic                    ok;
    logic signed [OFS_W-1:0] du;
    logic signed [OFS_W-1:0] dv;
  } side_t;

endpackage
`default_nettype wire

// ----- src/dggp_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage, with item side data.
`default_nettype none
module dggp_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_v,
  input  wire logic [dggp_pkg::NUM_W-1:0]      in_num [2],
  input  wire logic [dggp_pkg::DEN_W-1:0]      in_den [2],
  input  wire dggp_pkg::side_t                 in_side,
  output logic                                 out_v,
  output logic [dggp_pkg::NUM_W-1:0]           out_q [2],
  output dggp_pkg::side_t                      out_side
);
  localparam int NW = dggp_pkg::NUM_W;
  localparam int DW = dggp_pkg::DEN_W;

  logic                 v    [NW+1];
  dggp_pkg::side_t      side [NW+1];
  logic [DW-1:0]        rem  [NW+1][2];
  logic [NW-1:0]        num  [NW+1][2];
  logic [DW-1:0]        den  [NW+1][2];

  always_comb begin
    v[0]    = in_v;
    side[0] = in_side;
    for (int l = 0; l < 2; l++) begin
      rem[0][l] = '0;
      num[0][l] = in_num[l];
      den[0][l] = in_den[l];
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [DW:0] trial [2];
    logic        ge    [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem[i-1][l], num[i-1][l][NW-1]};
        ge[l]    = trial[l] >= {1'b0, den[i-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
      if (en) begin
        side[i] <= side[i-1];
        for (int l = 0; l < 2; l++) begin
          rem[i][l] <= ge[l] ? DW'(trial[l] - {1'b0, den[i-1][l]}) : DW'(trial[l]);
          num[i][l] <= {num[i-1][l][NW-2:0], ge[l]};
          den[i][l] <= den[i-1][l];
        end
      end
    end
  end

  assign out_v    = v[NW];
  assign out_side = side[NW];
  assign out_q[0] = num[NW][0];
  assign out_q[1] = num[NW][1];
endmodule
`default_nettype wire

// ----- src/dggp_trig.sv -----
// Free-running sine/cosine pipeline from the angle register, quarter-wave polynomial.
`default_nettype none
module dggp_trig #(
  parameter int FRAC_BITS       = dggp_pkg::FRAC_BITS_DEF,
  parameter int TRIG_TABLE_BITS = dggp_pkg::TRIG_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic [15:0]           angle,
  output logic signed [FRAC_BITS+1:0] sn,
  output logic signed [FRAC_BITS+1:0] cs
);
  localparam int TW = FRAC_BITS + 2;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [31:0] RND = 32'd1 << (29 - FRAC_BITS);

  logic [30:0] tp  [8][2];
  logic [30:0] t2p [8][2];
  logic [31:0] sp  [8][2];
  logic [1:0]  qp  [8];

  logic [31:0] phase;

  assign phase = {angle[15 -: TRIG_TABLE_BITS], (32 - TRIG_TABLE_BITS)'(0)};

  always_ff @(posedge clk) begin
    qp[0]    <= phase[31:30];
    tp[0][0] <= {1'b0, phase[29:0]};
    tp[0][1] <= 31'h4000_0000 - {1'b0, phase[29:0]};
    t2p[0][0] <= '0;
    t2p[0][1] <= '0;
    sp[0][0] <= '0;
    sp[0][1] <= '0;
  end

  for (genvar j = 1; j < 8; j++) begin : g_st
    logic [63:0] prod [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (j == 1) begin
          prod[l] = 64'(tp[j-1][l]) * 64'(tp[j-1][l]);
        end else if (j == 7) begin
          prod[l] = 64'(sp[j-1][l]) * 64'(tp[j-1][l]);
        end else begin
          prod[l] = 64'(sp[j-1][l]) * 64'(t2p[j-1][l]);
        end
      end
    end

    always_ff @(posedge clk) begin
      qp[j] <= qp[j-1];
      for (int l = 0; l < 2; l++) begin
        tp[j][l] <= tp[j-1][l];
        if (j == 1) begin
          t2p[j][l] <= prod[l][60:30];
          sp[j][l]  <= dggp_pkg::SINE_K[0];
        end else if (j == 7) begin
          t2p[j][l] <= t2p[j-1][l];
          sp[j][l]  <= prod[l][61:30];
        end else begin
          t2p[j][l] <= t2p[j-1][l];
          sp[j][l]  <= dggp_pkg::SINE_K[j-1] - prod[l][61:30];
        end
      end
    end
  end

  logic signed [TW-1:0] fa, fb;

  always_comb begin
    fa = TW'((sp[7][0] + RND) >> SH);
    fb = TW'((sp[7][1] + RND) >> SH);
  end

  always_ff @(posedge clk) begin
    case (qp[7])
      2'd0:    begin sn <= fa;  cs <= fb;  end
      2'd1:    begin sn <= fb;  cs <= -fa; end
      2'd2:    begin sn <= -fa; cs <= -fb; end
      default: begin sn <= -fb; cs <= fa;  end
    endcase
  end
endmodule
`default_nettype wire

// ----- src/decal_glyph_grid_projection.sv -----
// Throughput is one item per cycle while the skid stage is empty.
// Cost: the 40-stage quotient pipeline for the derived glyph steps sets the depth.
// A skid stage behind the output register lets one more item in while a result waits.
// Trig values settle after an angle write, well inside the item latency.
// Synchronous reset (rst) zeroes config registers and valid flags and empties the pipeline.
`default_nettype none
module decal_glyph_grid_projection #(
  parameter int FRAC_BITS       = dggp_pkg::FRAC_BITS_DEF,
  parameter int TRIG_TABLE_BITS = dggp_pkg::TRIG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // column[7:0], grid_row[15:8], compression[31:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // world_x[31:0], world_y[63:32], world_z[95:64]
  output logic [0:0]       m_tuser    // valid_res[0]
);
  localparam int NW = dggp_pkg::NUM_W;
  localparam int DW = dggp_pkg::DEN_W;
  localparam int OW = dggp_pkg::OFS_W;
  localparam int TW = FRAC_BITS + 2;
  localparam int RW = OW + NW + 1;
  localparam int CW = 64;
  localparam int LW = 63 - FRAC_BITS;
  localparam int PW = LW + TW;
  localparam int AW = PW + 2;
  localparam logic signed [CW-1:0] LIM  = CW'(64'sd1 <<< (61 - FRAC_BITS));
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] SMAX = AW'(32'sh7fff_ffff);
  localparam logic signed [AW-1:0] SMIN = AW'(32'sh8000_0000);
  localparam logic signed [TW-1:0] ONE  = TW'(1) <<< FRAC_BITS;

  // configuration registers
  logic [15:0] angle;
  logic [1:0]  surface;
  logic [31:0] origin_x, origin_y, origin_z;
  logic [63:0] extent, step_override;
  logic [15:0] grid_dims;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0; surface <= '0; origin_x <= '0; origin_y <= '0; origin_z <= '0;
      extent <= '0; grid_dims <= '0; step_override <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dggp_pkg::REG_ANGLE:    angle <= cfg_data[15:0];
        dggp_pkg::REG_SURFACE:  surface <= cfg_data[1:0];
        dggp_pkg::REG_ORIGIN_X: origin_x <= cfg_data[31:0];
        dggp_pkg::REG_ORIGIN_Y: origin_y <= cfg_data[31:0];
        dggp_pkg::REG_ORIGIN_Z: origin_z <= cfg_data[31:0];
        dggp_pkg::REG_EXTENT:   extent <= cfg_data;
        dggp_pkg::REG_GRID:     grid_dims <= cfg_data[15:0];
        dggp_pkg::REG_STEP:     step_override <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic skid_v;
  assign adv      = !skid_v;
  assign s_tready = adv;

  // stage 0: divisor, dividend and cell offsets
  logic [7:0]  cols, rows, column, grid_row;
  logic [15:0] comp;
  assign cols     = grid_dims[7:0];
  assign rows     = grid_dims[15:8];
  assign column   = s_tdata[7:0];
  assign grid_row = s_tdata[15:8];
  assign comp     = s_tdata[31:16];

  logic            st0_v;
  logic [NW-1:0]   st0_num [2];
  logic [DW-1:0]   st0_den [2];
  dggp_pkg::side_t st0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      st0_v <= 1'b0;
    end else if (adv) begin
      st0_v <= s_tvalid;
    end
    if (adv) begin
      st0_num[0]  <= {extent[31:0], 8'd0};
      st0_num[1]  <= {extent[63:32], 8'd0};
      st0_den[0]  <= DW'(cols) * DW'(comp);
      st0_den[1]  <= DW'(rows) * DW'(comp);
      st0_side.ok <= (cols != 8'd0) && (rows != 8'd0) && (comp != 16'd0);
      st0_side.du <= $signed({1'b0, column, 1'b0}) - $signed({2'b0, cols}) + OW'(1);
      st0_side.dv <= $signed({1'b0, grid_row, 1'b0}) - $signed({2'b0, rows}) + OW'(1);
    end
  end

  logic            dv_v;
  logic [NW-1:0]   dv_q [2];
  dggp_pkg::side_t dv_side;

  dggp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_v     (st0_v),
    .in_num   (st0_num),
    .in_den   (st0_den),
    .in_side  (st0_side),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  logic signed [TW-1:0] sn, cs;

  dggp_trig #(
    .FRAC_BITS       (FRAC_BITS),
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_trig (
    .clk   (clk),
    .angle (angle),
    .sn    (sn),
    .cs    (cs)
  );

  // m1: step select and offset product
  logic [NW-1:0] step_u, step_v;
  assign step_u = (step_override[31:0] != 32'd0) ? NW'(step_override[31:0]) : dv_q[0];
  assign step_v = (step_override[63:32] != 32'd0) ? NW'(step_override[63:32]) : dv_q[1];

  logic                 m1_v, m1_ok;
  logic signed [RW-1:0] m1_lu, m1_lv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= dv_v;
    end
    if (adv) begin
      m1_ok <= dv_side.ok;
      m1_lu <= RW'(dv_side.du) * $signed({1'b0, step_u});
      m1_lv <= RW'(dv_side.dv) * $signed({1'b0, step_v});
    end
  end

  // m2: clamp doubled offsets
  logic signed [CW-1:0] lu_w, lv_w;
  assign lu_w = CW'(m1_lu);
  assign lv_w = CW'(m1_lv);

  logic                 m2_v, m2_ok;
  logic signed [LW-1:0] m2_lu, m2_lv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (adv) begin
      m2_v <= m1_v;
    end
    if (adv) begin
      m2_ok <= m1_ok;
      m2_lu <= LW'((lu_w > LIM) ? LIM : ((lu_w < -LIM) ? -LIM : lu_w));
      m2_lv <= LW'((lv_w > LIM) ? LIM : ((lv_w < -LIM) ? -LIM : lv_w));
    end
  end

  // m3: basis products
  logic                 wall;
  logic signed [TW-1:0] tx, ty, bx, by, bz;
  always_comb begin
    wall = (surface == dggp_pkg::SURF_WALL);
    tx = wall ? sn : cs;
    ty = wall ? -cs : sn;
    bx = wall ? TW'(0) : -sn;
    by = wall ? TW'(0) : cs;
    bz = wall ? -ONE : TW'(0);
  end

  logic                 m3_v, m3_ok;
  logic signed [PW-1:0] m3_xt, m3_xb, m3_yt, m3_yb, m3_zb;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (adv) begin
      m3_v <= m2_v;
    end
    if (adv) begin
      m3_ok <= m2_ok;
      m3_xt <= PW'(m2_lu) * PW'(tx);
      m3_xb <= PW'(m2_lv) * PW'(bx);
      m3_yt <= PW'(m2_lu) * PW'(ty);
      m3_yb <= PW'(m2_lv) * PW'(by);
      m3_zb <= PW'(m2_lv) * PW'(bz);
    end
  end

  // m4: sum with origin and rounding bias
  logic                 m4_v, m4_ok;
  logic signed [AW-1:0] m4_ax, m4_ay, m4_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_v <= 1'b0;
    end else if (adv) begin
      m4_v <= m3_v;
    end
    if (adv) begin
      m4_ok <= m3_ok;
      m4_ax <= AW'(m3_xt) + AW'(m3_xb) + (AW'($signed(origin_x)) <<< (FRAC_BITS + 1)) + HALF;
      m4_ay <= AW'(m3_yt) + AW'(m3_yb) + (AW'($signed(origin_y)) <<< (FRAC_BITS + 1)) + HALF;
      m4_az <= AW'(m3_zb) + (AW'($signed(origin_z)) <<< (FRAC_BITS + 1)) + HALF;
    end
  end

  // m5: shift, saturate, zero invalid items
  logic signed [AW-1:0] sx, sy, sz;
  assign sx = m4_ax >>> (FRAC_BITS + 1);
  assign sy = m4_ay >>> (FRAC_BITS + 1);
  assign sz = m4_az >>> (FRAC_BITS + 1);

  logic        p_v, p_ok;
  logic [31:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= m4_v;
    end
    if (adv) begin
      p_ok <= m4_ok;
      px <= !m4_ok ? 32'd0 : (sx > SMAX) ? 32'h7fff_ffff : (sx < SMIN) ? 32'h8000_0000
                                        : sx[31:0];
      py <= !m4_ok ? 32'd0 : (sy > SMAX) ? 32'h7fff_ffff : (sy < SMIN) ? 32'h8000_0000
                                        : sy[31:0];
      pz <= !m4_ok ? 32'd0 : (sz > SMAX) ? 32'h7fff_ffff : (sz < SMIN) ? 32'h8000_0000
                                        : sz[31:0];
    end
  end

  // output register with skid
  logic        out_v;
  logic [95:0] out_data, skid_data;
  logic        out_ok, skid_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (m_tready || !out_v) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= p_v;
      end
    end else if (adv && p_v) begin
      skid_v <= 1'b1;
    end
    if (m_tready || !out_v) begin
      if (skid_v) begin
        out_data <= skid_data;
        out_ok   <= skid_ok;
      end else begin
        out_data <= {pz, py, px};
        out_ok   <= p_ok;
      end
    end else if (adv && p_v) begin
      skid_data <= {pz, py, px};
      skid_ok   <= p_ok;
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = out_data;
  assign m_tuser[0] = out_ok;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid holds an item while the output register is empty");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser[0]) |-> (m_tdata == 96'd0))
    else $error("invalid result carries nonzero coordinates");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
      (skid_v && m_tready) |=> out_v)
    else $error("skid item lost on drain");

endmodule
`default_nettype wire
